// ===== rtl/core/rtphp_pkg.sv =====
// ----------------------------------------------------------------------------
// RTP header parser package
// Shared constants, status codes and the packet snapshot type.
// ----------------------------------------------------------------------------
package rtphp_pkg;

   // Default bound on the number of bytes counted in one packet.
   localparam int MAX_PACKET_BYTES_DEF = 65535;

   // Fixed header and extension header sizes in bytes.
   localparam int HDR_BYTES = 12;
   localparam int EXT_BYTES = 4;

   // Header constants.
   localparam logic [1:0] HDR_VERSION = 2'd2;
   localparam logic [6:0] PT_SR       = 7'd72;
   localparam logic [6:0] PT_RR       = 7'd73;
   localparam logic [15:0] OFFSET_MAX = 16'hFFFF;

   // Status codes.
   localparam logic [2:0] ERR_OK       = 3'd0;
   localparam logic [2:0] ERR_SHORT    = 3'd1;
   localparam logic [2:0] ERR_VERSION  = 3'd2;
   localparam logic [2:0] ERR_RTCP     = 3'd3;
   localparam logic [2:0] ERR_ZERO_PAD = 3'd4;
   localparam logic [2:0] ERR_OVERRUN  = 3'd5;

   // Packet state captured on the final byte. Header byte 0 sits at the top.
   typedef struct packed {
      logic [95:0] header;
      logic [31:0] ext;
      logic [15:0] length;
      logic        overflow;
      logic [7:0]  final_byte;
   } snap_type;

   // One result item.
   typedef struct packed {
      logic        accepted;
      logic [2:0]  error_code;
      logic [6:0]  payload_type;
      logic        marker;
      logic [3:0]  csrc_count;
      logic [15:0] sequence_number;
      logic [31:0] time_stamp;
      logic [31:0] sync_source;
      logic [15:0] extension_id;
      logic [15:0] payload_offset;
      logic [7:0]  pad_count;
      logic [15:0] payload_length;
   } rsp_type;

endpackage

// ===== rtl/core/rtphp_if.sv =====
// ----------------------------------------------------------------------------
// RTP header parser channels
// Valid/ready channels for packet bytes and for parse results.
// ----------------------------------------------------------------------------

// Packet byte channel.
interface rtphp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, data_byte, last_byte, input ready);
   modport sink (input valid, data_byte, last_byte, output ready);
endinterface

// Parse result channel.
interface rtphp_rsp_if;
   logic        valid;
   logic        ready;
   logic        accepted;
   logic [2:0]  error_code;
   logic [6:0]  payload_type;
   logic        marker;
   logic [3:0]  csrc_count;
   logic [15:0] sequence_number;
   logic [31:0] time_stamp;
   logic [31:0] sync_source;
   logic [15:0] extension_id;
   logic [15:0] payload_offset;
   logic [7:0]  pad_count;
   logic [15:0] payload_length;

   modport source (output valid, accepted, error_code, payload_type, marker, csrc_count,
                   sequence_number, time_stamp, sync_source, extension_id,
                   payload_offset, pad_count, payload_length, input ready);
   modport sink (input valid, accepted, error_code, payload_type, marker, csrc_count,
                 sequence_number, time_stamp, sync_source, extension_id,
                 payload_offset, pad_count, payload_length, output ready);
endinterface

// ===== rtl/core/rtphp_capture.sv =====
// ----------------------------------------------------------------------------
// RTP header byte capture
// Counts packet bytes, stores the fixed header and the extension header,
// and presents the updated packet state for the snapshot on the final byte.
// ----------------------------------------------------------------------------
module rtphp_capture import rtphp_pkg::*; #(
   parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_valid,
   input  logic [7:0] data_byte,
   input  logic       last_byte,
   output snap_type   snap
);

   localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 1);
   localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
   localparam int HDR_IDX_W = $clog2(HDR_BYTES);
   localparam int EXT_IDX_W = $clog2(EXT_BYTES);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PACKET_BYTES);

   logic [CNT_W-1:0] count_ff, count_upd, count_in;
   logic             ovf_ff, ovf_upd, ovf_in;
   logic [7:0]       hdr_ff  [HDR_BYTES];
   logic [7:0]       hdr_in  [HDR_BYTES];
   logic [7:0]       ext_ff  [EXT_BYTES];
   logic [7:0]       ext_upd [EXT_BYTES];
   logic [7:0]       ext_in  [EXT_BYTES];

   logic [CMP_W-1:0] pos;
   logic [CMP_W-1:0] ext_base;
   logic [CMP_W-1:0] ext_rel;
   logic             ext_hit;

   // Where the extension header starts, from the stored CSRC count.
   always_comb begin
      pos      = CMP_W'(count_ff);
      ext_base = CMP_W'(HDR_BYTES) + CMP_W'({hdr_ff[0][3:0], 2'b00});
      ext_rel  = pos - ext_base;
      ext_hit  = (pos >= ext_base) && (ext_rel < CMP_W'(EXT_BYTES));
   end

   // Apply one byte transfer to the packet state.
   always_comb begin
      count_upd = count_ff;
      ovf_upd   = ovf_ff;
      hdr_in    = hdr_ff;
      ext_upd   = ext_ff;
      if (byte_valid) begin
         if (count_ff >= CNT_MAX) begin
            ovf_upd = 1'b1;
         end else begin
            if (pos < CMP_W'(HDR_BYTES)) begin
               hdr_in[count_ff[HDR_IDX_W-1:0]] = data_byte;
            end else if (hdr_ff[0][4] && ext_hit) begin
               ext_upd[ext_rel[EXT_IDX_W-1:0]] = data_byte;
            end
            count_upd = count_ff + 1'b1;
         end
      end
   end

   // The final byte starts a fresh packet.
   always_comb begin
      count_in = count_upd;
      ovf_in   = ovf_upd;
      ext_in   = ext_upd;
      if (byte_valid && last_byte) begin
         count_in = '0;
         ovf_in   = 1'b0;
         for (int i = 0; i < EXT_BYTES; i++) begin
            ext_in[i] = 8'd0;
         end
      end
   end

   // Snapshot view of the updated state.
   always_comb begin
      snap.header = '0;
      snap.ext    = '0;
      for (int i = 0; i < HDR_BYTES; i++) begin
         snap.header[95 - 8*i -: 8] = hdr_in[i];
      end
      for (int i = 0; i < EXT_BYTES; i++) begin
         snap.ext[31 - 8*i -: 8] = ext_upd[i];
      end
      snap.length     = 16'(count_upd);
      snap.overflow   = ovf_upd;
      snap.final_byte = data_byte;
   end

   // Control state and extension bytes clear on reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         for (int i = 0; i < EXT_BYTES; i++) begin
            ext_ff[i] <= 8'd0;
         end
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         ext_ff   <= ext_in;
      end
   end

   // Header bytes are plain storage.
   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
   end

endmodule

// ===== rtl/core/rtp_header_parser.sv =====
// A result is offered through three registers after the edge at which a packet's final byte
// transfers: snapshot, offset stage and result.
// Throughput: one packet byte per cycle; each stage holds one packet, so a packet of
// any length (one byte upward) follows the previous one without a gap.
// Back pressure on the result channel fills the three stages; with all three full, byte
// transfers stall until the result transfers. Reset (synchronous, active high) empties
// all stages and starts a fresh packet.
// ----------------------------------------------------------------------------
// RTP header parser
// Parses RTP fixed and extension headers from a byte stream and reports the
// header fields, payload offset and length, and a status code per packet.
// ----------------------------------------------------------------------------
module rtp_header_parser import rtphp_pkg::*; #(
   parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
   input  logic   clock,
   input  logic   reset,
   rtphp_req_if.sink   req_chan,
   rtphp_rsp_if.source rsp_chan
);

   // Pipeline handshake signals.
   logic req_fire;
   logic out_open, s2_open, s1_open;
   logic s1_move, s2_move;

   snap_type snap;
   snap_type snap_ff, snap_in;
   logic     s1_valid_ff, s1_valid_in;

   logic [95:0] s2_hdr_ff, s2_hdr_in;
   logic [15:0] s2_ext_id_ff, s2_ext_id_in;
   logic [15:0] s2_offset_ff, s2_offset_in;
   logic        s2_sat_ff, s2_sat_in;
   logic [7:0]  s2_pad_ff, s2_pad_in;
   logic [15:0] s2_len_ff, s2_len_in;
   logic        s2_ovf_ff, s2_ovf_in;
   logic        s2_zero_pad_ff, s2_zero_pad_in;
   logic        s2_valid_ff, s2_valid_in;

   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;

   // A stage can load when it is empty or its content moves on.
   always_comb begin
      out_open = !rsp_valid_ff || rsp_chan.ready;
      s2_open  = !s2_valid_ff || out_open;
      s1_open  = !s1_valid_ff || s2_open;
      s2_move  = s2_valid_ff && out_open;
      s1_move  = s1_valid_ff && s2_open;
      req_fire = req_chan.valid && s1_open;
   end

   assign req_chan.ready = s1_open;

   // Byte capture and packet state.
   rtphp_capture #(
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
   ) u_capture (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_fire),
      .data_byte  (req_chan.data_byte),
      .last_byte  (req_chan.last_byte),
      .snap       (snap)
   );

   // Stage 1: hold the packet snapshot taken on the final byte transfer.
   always_comb begin
      snap_in     = snap_ff;
      s1_valid_in = s1_valid_ff && !s1_move;
      if (req_fire && req_chan.last_byte) begin
         snap_in     = snap;
         s1_valid_in = 1'b1;
      end
   end

   // Stage 2: payload offset with saturation, padding count.
   logic [7:0]  s1_b0;
   logic [18:0] offset_full;
   logic [18:0] ext_span;

   always_comb begin
      s1_b0    = snap_ff.header[95:88];
      ext_span = s1_b0[4] ? (19'd4 + 19'({snap_ff.ext[15:0], 2'b00})) : 19'd0;
      offset_full = 19'(HDR_BYTES) + 19'({s1_b0[3:0], 2'b00}) + ext_span;

      s2_hdr_in      = s2_hdr_ff;
      s2_ext_id_in   = s2_ext_id_ff;
      s2_offset_in   = s2_offset_ff;
      s2_sat_in      = s2_sat_ff;
      s2_pad_in      = s2_pad_ff;
      s2_len_in      = s2_len_ff;
      s2_ovf_in      = s2_ovf_ff;
      s2_zero_pad_in = s2_zero_pad_ff;
      s2_valid_in    = s2_valid_ff && !s2_move;
      if (s1_move) begin
         s2_hdr_in      = snap_ff.header;
         s2_ext_id_in   = s1_b0[4] ? snap_ff.ext[31:16] : 16'd0;
         s2_sat_in      = offset_full > 19'(OFFSET_MAX);
         s2_offset_in   = s2_sat_in ? OFFSET_MAX : offset_full[15:0];
         s2_pad_in      = s1_b0[5] ? snap_ff.final_byte : 8'd0;
         s2_zero_pad_in = s1_b0[5] && (snap_ff.final_byte == 8'd0);
         s2_len_in      = snap_ff.length;
         s2_ovf_in      = snap_ff.overflow;
         s2_valid_in    = 1'b1;
      end
   end

   // Stage 3: checks in priority order and the payload length.
   logic [16:0] need_bytes;
   logic        overrun;
   logic [2:0]  code;
   logic        short_pkt;

   always_comb begin
      need_bytes = {1'b0, s2_offset_ff} + 17'(s2_pad_ff);
      overrun    = s2_sat_ff || s2_ovf_ff || (need_bytes > {1'b0, s2_len_ff});
      short_pkt  = s2_len_ff < 16'(HDR_BYTES);

      if (short_pkt) begin
         code = ERR_SHORT;
      end else if (s2_hdr_ff[95:94] != HDR_VERSION) begin
         code = ERR_VERSION;
      end else if (s2_hdr_ff[87] && (s2_hdr_ff[86:80] == PT_SR ||
                                     s2_hdr_ff[86:80] == PT_RR)) begin
         code = ERR_RTCP;
      end else if (s2_zero_pad_ff) begin
         code = ERR_ZERO_PAD;
      end else if (overrun) begin
         code = ERR_OVERRUN;
      end else begin
         code = ERR_OK;
      end

      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (s2_move) begin
         rsp_valid_in = 1'b1;
         if (short_pkt) begin
            rsp_in            = '0;
            rsp_in.error_code = ERR_SHORT;
         end else begin
            rsp_in.accepted        = (code == ERR_OK);
            rsp_in.error_code      = code;
            rsp_in.payload_type    = s2_hdr_ff[86:80];
            rsp_in.marker          = s2_hdr_ff[87];
            rsp_in.csrc_count      = s2_hdr_ff[91:88];
            rsp_in.sequence_number = s2_hdr_ff[79:64];
            rsp_in.time_stamp      = s2_hdr_ff[63:32];
            rsp_in.sync_source     = s2_hdr_ff[31:0];
            rsp_in.extension_id    = s2_ext_id_ff;
            rsp_in.payload_offset  = s2_offset_ff;
            rsp_in.pad_count       = s2_pad_ff;
            rsp_in.payload_length  = (code == ERR_OK) ?
                                     (s2_len_ff - 16'(s2_pad_ff) - s2_offset_ff) : 16'd0;
         end
      end
   end

   // Stage valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      snap_ff        <= snap_in;
      s2_hdr_ff      <= s2_hdr_in;
      s2_ext_id_ff   <= s2_ext_id_in;
      s2_offset_ff   <= s2_offset_in;
      s2_sat_ff      <= s2_sat_in;
      s2_pad_ff      <= s2_pad_in;
      s2_len_ff      <= s2_len_in;
      s2_ovf_ff      <= s2_ovf_in;
      s2_zero_pad_ff <= s2_zero_pad_in;
      rsp_ff         <= rsp_in;
   end

   // Result channel outputs.
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.accepted        = rsp_ff.accepted;
   assign rsp_chan.error_code      = rsp_ff.error_code;
   assign rsp_chan.payload_type    = rsp_ff.payload_type;
   assign rsp_chan.marker          = rsp_ff.marker;
   assign rsp_chan.csrc_count      = rsp_ff.csrc_count;
   assign rsp_chan.sequence_number = rsp_ff.sequence_number;
   assign rsp_chan.time_stamp      = rsp_ff.time_stamp;
   assign rsp_chan.sync_source     = rsp_ff.sync_source;
   assign rsp_chan.extension_id    = rsp_ff.extension_id;
   assign rsp_chan.payload_offset  = rsp_ff.payload_offset;
   assign rsp_chan.pad_count       = rsp_ff.pad_count;
   assign rsp_chan.payload_length  = rsp_ff.payload_length;

endmodule

// ===== rtl/core/rtphp_checker.sv =====
// ----------------------------------------------------------------------------
// RTP header parser checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module rtphp_checker import rtphp_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        accepted,
   input logic [2:0]  error_code,
   input logic [15:0] payload_offset,
   input logic [7:0]  pad_count,
   input logic [15:0] payload_length
);

   // A stalled result stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // A stalled result keeps its status and length.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(error_code) && $stable(payload_length))
      else $error("result changed while stalled");

   // The accept flag agrees with the status code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (accepted == (error_code == ERR_OK)))
      else $error("accept flag disagrees with status");

   // A rejected packet reports no payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (error_code != ERR_OK) |-> (payload_length == 16'd0))
      else $error("payload length on rejected packet");

   // A short packet reports no offset and no padding.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (error_code == ERR_SHORT) |->
         (payload_offset == 16'd0) && (pad_count == 8'd0))
      else $error("short packet carries header data");

endmodule

bind rtp_header_parser rtphp_checker u_rtphp_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .accepted       (rsp_chan.accepted),
   .error_code     (rsp_chan.error_code),
   .payload_offset (rsp_chan.payload_offset),
   .pad_count      (rsp_chan.pad_count),
   .payload_length (rsp_chan.payload_length)
);
